[rtl/button_gesture_detector_defines.svh]
// Assertion macros shared by the gesture detector top level and core.
`ifndef BUTTON_GESTURE_DETECTOR_DEFINES_SVH
`define BUTTON_GESTURE_DETECTOR_DEFINES_SVH

// Concurrent property, checked on every rising clock edge outside reset.
`define BGD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Antecedent this cycle, consequent on the next edge.
`define BGD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bgd_pkg.sv]
// Shared types, event codes and configuration defaults for the gesture detector.
package bgd_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 16;
    localparam int NOW_W          = 32;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int EVENT_W        = 3;

    localparam logic [CFG_W-1:0] WINDOW_RST = 16'd500;
    localparam logic [CFG_W-1:0] DELAY_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] PERIOD_RST = 16'd250;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 3'd0,
        EV_CLICK  = 3'd1,
        EV_DOUBLE = 3'd2,
        EV_LONG   = 3'd3,
        EV_REPEAT = 3'd4
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW = 2'd0,
        REG_DELAY  = 2'd1,
        REG_PERIOD = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] window;
        logic [CFG_W-1:0] delay;
        logic [CFG_W-1:0] period;
    } cfg_t;

endpackage

[rtl/button_gesture_detector.sv]
// Top level: request input register, gesture core, result register and config port.
// One key poll (level and millisecond time) goes in per request and exactly one event
// comes out per poll: 0 none, 1 click, 2 double click, 3 long press, 4 repeat press.
// Polls are accepted every cycle when the result side keeps up; a poll's event is
// written to the result register when the held poll is processed, which waits while
// an earlier event in the result register is not taken. The rate is set by the gesture
// state update, a loop through the time difference, the count-times-period multiply
// and the compare. The result register lets a new poll in while the previous event
// waits to be taken. Configuration writes are always ready and take effect on the next
// edge; indexes beyond the register list are ignored.
module button_gesture_detector #(
    parameter int TIME_BITS  = bgd_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = bgd_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            key_valid,
    output logic                            key_ready,
    input  logic                            pressed,
    input  logic [bgd_pkg::NOW_W-1:0]       now_ms,
    output logic                            evt_valid,
    input  logic                            evt_ready,
    output logic [bgd_pkg::EVENT_W-1:0]     event_res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bgd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bgd_pkg::CFG_W-1:0]       cfg_data
);
    import bgd_pkg::*;

    logic                 s1_valid_reg;
    logic                 s1_pressed_reg;
    logic [TIME_BITS-1:0] s1_now_reg;
    logic                 evt_valid_reg;
    logic [EVENT_W-1:0]   evt_reg;
    logic                 step;
    cfg_t                 cfg;
    event_t               ev;

    assign cfg_ready = 1'b1;
    assign step      = s1_valid_reg && (!evt_valid_reg || evt_ready);
    assign key_ready = !s1_valid_reg || step;

    bgd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bgd_core #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .pressed (s1_pressed_reg),
        .now     (s1_now_reg),
        .cfg     (cfg),
        .ev      (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            if (key_ready)
                s1_valid_reg <= key_valid;
            if (step)
                evt_valid_reg <= 1'b1;
            else if (evt_ready)
                evt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_valid && key_ready)
        begin
            s1_pressed_reg <= pressed;
            // time is kept modulo 2^TIME_BITS
            s1_now_reg     <= TIME_BITS'(now_ms);
        end
        if (step)
            evt_reg <= EVENT_W'(ev);
    end

    assign evt_valid = evt_valid_reg;
    assign event_res = evt_reg;

`include "button_gesture_detector_defines.svh"

    `BGD_ASSERT(a_full_stall_blocks, (s1_valid_reg && !step) |-> !key_ready,
                "input taken while stage full")
    `BGD_ASSERT_NEXT(a_step_fills_out, step, evt_valid_reg,
                     "processed poll produced no event")
    `BGD_ASSERT_NEXT(a_stage_holds, s1_valid_reg && !step,
                     s1_valid_reg && $stable(s1_now_reg) && $stable(s1_pressed_reg),
                     "held poll changed")

endmodule

[rtl/bgd_cfg_regs.sv]
// Configuration register file: double-click window, long-press delay, repeat period.
module bgd_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [bgd_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [bgd_pkg::CFG_W-1:0]      wr_data,
    output bgd_pkg::cfg_t                  cfg
);
    import bgd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window <= WINDOW_RST;
            cfg_reg.delay  <= DELAY_RST;
            cfg_reg.period <= PERIOD_RST;
        end
        else if (wr_en)
        begin
            // unlisted index: request is taken and dropped
            unique case (wr_index)
                REG_WINDOW: cfg_reg.window <= wr_data;
                REG_DELAY:  cfg_reg.delay  <= wr_data;
                REG_PERIOD: cfg_reg.period <= wr_data;
                default:    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/bgd_core.sv]
// Gesture state and per-poll event decision, updated once per processed request.
module bgd_core #(
    parameter int TIME_BITS  = bgd_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = bgd_pkg::COUNT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 pressed,
    input  logic [TIME_BITS-1:0] now,
    input  bgd_pkg::cfg_t        cfg,
    output bgd_pkg::event_t      ev
);
    import bgd_pkg::*;

    localparam int NEED_W = COUNT_BITS + CFG_W;
    localparam int CMP_W  = (TIME_BITS > NEED_W) ? TIME_BITS : NEED_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                  was_down_reg, was_down_next;
    logic                  double_seen_reg, double_seen_next;
    logic                  touch_valid_reg, touch_valid_next;
    logic [TIME_BITS-1:0]  touch_stamp_reg, touch_stamp_next;
    logic [COUNT_BITS-1:0] fire_count_reg, fire_count_next;

    logic [TIME_BITS-1:0]  elapsed;
    logic [TIME_BITS-1:0]  delay_ext;
    logic [TIME_BITS-1:0]  since;
    logic [NEED_W-1:0]     need;
    logic                  double_hit;
    logic                  long_hit;
    logic                  repeat_hit;
    event_t                ev_next;

    // all differences wrap at the time width
    assign elapsed    = now - touch_stamp_reg;
    assign delay_ext  = TIME_BITS'(cfg.delay);
    assign since      = elapsed - delay_ext;
    assign need       = NEED_W'(fire_count_reg) * NEED_W'(cfg.period);
    assign double_hit = touch_valid_reg && (elapsed < TIME_BITS'(cfg.window));
    assign long_hit   = elapsed >= delay_ext;
    assign repeat_hit = (CMP_W'(need) <= CMP_W'(since)) && (fire_count_reg != COUNT_MAX);

    always_comb
    begin
        was_down_next    = was_down_reg;
        double_seen_next = double_seen_reg;
        touch_valid_next = touch_valid_reg;
        touch_stamp_next = touch_stamp_reg;
        fire_count_next  = fire_count_reg;
        ev_next          = EV_NONE;
        priority if (!pressed && !was_down_reg)
        begin
            double_seen_next = 1'b0;
            fire_count_next  = '0;
        end
        else if (pressed && !was_down_reg)
        begin
            was_down_next = 1'b1;
            if (double_hit)
            begin
                // keeps the recorded touch and the old count
                double_seen_next = 1'b1;
                ev_next          = EV_DOUBLE;
            end
            else
            begin
                touch_stamp_next = now;
                touch_valid_next = 1'b1;
                double_seen_next = 1'b0;
                fire_count_next  = '0;
            end
        end
        else if (!pressed)
        begin
            was_down_next = 1'b0;
            if (!double_seen_reg && (fire_count_reg == '0))
                ev_next = EV_CLICK;
        end
        else if (fire_count_reg == '0)
        begin
            if (long_hit)
            begin
                fire_count_next = COUNT_BITS'(1);
                ev_next         = EV_LONG;
            end
        end
        else
        begin
            if (repeat_hit)
            begin
                fire_count_next = fire_count_reg + COUNT_BITS'(1);
                ev_next         = EV_REPEAT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_down_reg    <= 1'b0;
            double_seen_reg <= 1'b0;
            touch_valid_reg <= 1'b0;
            touch_stamp_reg <= '0;
            fire_count_reg  <= '0;
        end
        else if (step)
        begin
            was_down_reg    <= was_down_next;
            double_seen_reg <= double_seen_next;
            touch_valid_reg <= touch_valid_next;
            touch_stamp_reg <= touch_stamp_next;
            fire_count_reg  <= fire_count_next;
        end
    end

    assign ev = ev_next;

`include "button_gesture_detector_defines.svh"

    `BGD_ASSERT(a_double_needs_touch, double_seen_reg |-> touch_valid_reg, "double flag without touch")
    `BGD_ASSERT_NEXT(a_long_sets_one, step && (ev_next == EV_LONG), fire_count_reg == COUNT_BITS'(1), "long press did not set count to one")
    `BGD_ASSERT_NEXT(a_repeat_counts, step && (ev_next == EV_REPEAT), fire_count_reg == $past(fire_count_reg) + COUNT_BITS'(1), "repeat did not advance count")

endmodule
